/* rtl/fbp2png_pkg.sv */
`default_nettype none
package fbp2png_pkg;

  localparam int MAX_WIDTH_DEFAULT = 2048;
  localparam int ROW_LIMIT         = 2048;
  localparam int ROW_W             = $clog2(ROW_LIMIT);
  localparam int DIM_W             = 12;
  localparam int LAYOUT_W          = 10;
  localparam int PIXEL_W           = 32;
  localparam int RGB_W             = 24;
  localparam int PAIR_W            = 27;
  localparam int CFG_INDEX_W       = 3;
  localparam int CFG_DATA_W        = 12;
  localparam int OUTQ_DEPTH        = 3;
  localparam int OUTQ_PTR_W        = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_WIDE_PIXEL     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RED_LAYOUT     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GREEN_LAYOUT   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BLUE_LAYOUT    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_SCALE     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_WIDTH  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_HEIGHT = 3'd6;

  localparam logic                RST_WIDE_PIXEL     = 1'b1;
  localparam logic [LAYOUT_W-1:0] RST_RED_LAYOUT     = 10'd520;
  localparam logic [LAYOUT_W-1:0] RST_GREEN_LAYOUT   = 10'd264;
  localparam logic [LAYOUT_W-1:0] RST_BLUE_LAYOUT    = 10'd8;
  localparam logic                RST_HALF_SCALE     = 1'b0;
  localparam logic [DIM_W-1:0]    RST_DISPLAY_WIDTH  = 12'd800;
  localparam logic [DIM_W-1:0]    RST_DISPLAY_HEIGHT = 12'd480;

  typedef struct packed {
    logic                wide_pixel;
    logic [LAYOUT_W-1:0] red_layout;
    logic [LAYOUT_W-1:0] green_layout;
    logic [LAYOUT_W-1:0] blue_layout;
  } unpack_cfg_t;

  typedef struct packed {
    logic       frame_end;
    logic       row_start;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } out_beat_t;

endpackage
`default_nettype wire

/* rtl/framebuffer_pixel_to_png_scanline_unit.sv */
`default_nettype none
// Framebuffer pixel words in, PNG Up-filtered RGB bytes out.
// s_* carries one raw pixel word per beat in display order; m_* carries one
// filtered pixel per beat, m_tuser marking the first pixel of each scanline
// (the filter type byte goes in front of it downstream) and m_tlast the last
// pixel of the frame. Registers are written through cfg_*; the user must
// write them only while the stream is idle, which the block does not enforce.
// Throughput: one beat per cycle while s_tready is high, set by the one
// read and one write port a cycle on each of the line store and the
// previous-row store. A taken beat is registered by the unpacker and the
// store reads, then filtered and pushed into the three-entry output queue,
// which offers it.
// In half-scale mode only the odd-column beats of odd rows yield a result.
// Reset restores register defaults and returns to column 0, row 0; the
// stores are not cleared and every entry is written before it is read.
// When the receiver stalls the output queue fills and s_tready drops once
// the results waiting and in flight reach three; nothing is lost.
module framebuffer_pixel_to_png_scanline_unit #(
  parameter int MAX_WIDTH = fbp2png_pkg::MAX_WIDTH_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_wen,
  input  wire logic [fbp2png_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [fbp2png_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  input  wire logic [31:0]                           s_tdata,  // pixel_word
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  output logic      [23:0]                           m_tdata,  // out_blue, out_green, out_red
  output logic                                       m_tuser,  // row_start
  output logic                                       m_tlast   // frame_end
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int BOX_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int BAW = (BOX_DEPTH > 1) ? $clog2(BOX_DEPTH) : 1;
  localparam int RW  = fbp2png_pkg::ROW_W;
  localparam int HW  = fbp2png_pkg::DIM_W;

  typedef struct packed {
    logic           emit;
    logic           box_we;
    logic           half;
    logic           odd_col;
    logic           oy_zero;
    logic           row_start;
    logic           frame_end;
    logic           fwd_prev;
    logic           fwd_box;
    logic [CW-1:0]  paddr;
    logic [BAW-1:0] baddr;
  } stage_t;

  logic                                  wide_pixel;
  logic [fbp2png_pkg::LAYOUT_W-1:0]      red_layout;
  logic [fbp2png_pkg::LAYOUT_W-1:0]      green_layout;
  logic [fbp2png_pkg::LAYOUT_W-1:0]      blue_layout;
  logic                                  half_scale;
  logic [HW-1:0]                         display_width;
  logic [HW-1:0]                         display_height;

  logic [CW-1:0]  col;
  logic [RW-1:0]  row;
  logic [CW-1:0]  col_half;
  logic [RW-1:0]  row_half;
  logic [WW-1:0]  w_sat;
  logic [HW-1:0]  h_sat;
  logic [WW-1:0]  ow;
  logic [HW-1:0]  oh;
  logic           accept;
  logic           in_x;

  stage_t         st;
  stage_t         st_next;
  logic           st_valid;

  logic [fbp2png_pkg::PAIR_W-1:0] pair_sum;
  logic [fbp2png_pkg::PAIR_W-1:0] pair;
  logic [fbp2png_pkg::PAIR_W-1:0] box_q;
  logic [fbp2png_pkg::PAIR_W-1:0] above;
  logic [fbp2png_pkg::PAIR_W-1:0] fwd_box_data;
  logic [fbp2png_pkg::RGB_W-1:0]  px;
  logic [fbp2png_pkg::RGB_W-1:0]  cur;
  logic [fbp2png_pkg::RGB_W-1:0]  cur_half;
  logic [fbp2png_pkg::RGB_W-1:0]  prev_q;
  logic [fbp2png_pkg::RGB_W-1:0]  prev;
  logic [fbp2png_pkg::RGB_W-1:0]  fwd_prev_data;
  logic [fbp2png_pkg::RGB_W-1:0]  res;

  logic                                  push;
  fbp2png_pkg::out_beat_t                push_beat;
  fbp2png_pkg::out_beat_t                m_beat;
  logic [fbp2png_pkg::OUTQ_PTR_W-1:0]    level;
  fbp2png_pkg::unpack_cfg_t              ucfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_pixel     <= fbp2png_pkg::RST_WIDE_PIXEL;
      red_layout     <= fbp2png_pkg::RST_RED_LAYOUT;
      green_layout   <= fbp2png_pkg::RST_GREEN_LAYOUT;
      blue_layout    <= fbp2png_pkg::RST_BLUE_LAYOUT;
      half_scale     <= fbp2png_pkg::RST_HALF_SCALE;
      display_width  <= fbp2png_pkg::RST_DISPLAY_WIDTH;
      display_height <= fbp2png_pkg::RST_DISPLAY_HEIGHT;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        fbp2png_pkg::REG_WIDE_PIXEL:     wide_pixel     <= cfg_wdata[0];
        fbp2png_pkg::REG_RED_LAYOUT:     red_layout     <= cfg_wdata[9:0];
        fbp2png_pkg::REG_GREEN_LAYOUT:   green_layout   <= cfg_wdata[9:0];
        fbp2png_pkg::REG_BLUE_LAYOUT:    blue_layout    <= cfg_wdata[9:0];
        fbp2png_pkg::REG_HALF_SCALE:     half_scale     <= cfg_wdata[0];
        fbp2png_pkg::REG_DISPLAY_WIDTH:  display_width  <= cfg_wdata;
        fbp2png_pkg::REG_DISPLAY_HEIGHT: display_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign ucfg = '{wide_pixel: wide_pixel, red_layout: red_layout,
                  green_layout: green_layout, blue_layout: blue_layout};

  assign s_tready = ({1'b0, level} + {2'b00, st_valid && st.emit}) <= 3'd2;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    if (display_width == '0) begin
      w_sat = WW'(1);
    end else if (32'(display_width) > MAX_WIDTH) begin
      w_sat = WW'(MAX_WIDTH);
    end else begin
      w_sat = WW'(display_width);
    end
    if (display_height == '0) begin
      h_sat = HW'(1);
    end else if (32'(display_height) > fbp2png_pkg::ROW_LIMIT) begin
      h_sat = HW'(fbp2png_pkg::ROW_LIMIT);
    end else begin
      h_sat = display_height;
    end
  end

  assign ow       = w_sat >> 1;
  assign oh       = h_sat >> 1;
  assign col_half = col >> 1;
  assign row_half = row >> 1;
  assign in_x     = WW'(col_half) < ow;

  always_comb begin
    st_next         = '0;
    st_next.half    = half_scale;
    st_next.odd_col = col[0];
    st_next.baddr   = BAW'(col_half);
    if (!half_scale) begin
      st_next.emit      = (WW'(col) < w_sat) && (HW'(row) < h_sat);
      st_next.paddr     = col;
      st_next.oy_zero   = (row == '0);
      st_next.row_start = (col == '0);
      st_next.frame_end = (WW'(col) == w_sat - 1'b1) && (HW'(row) == h_sat - 1'b1);
    end else begin
      st_next.box_we    = col[0] && in_x && !row[0];
      st_next.emit      = col[0] && in_x && row[0] && (HW'(row_half) < oh);
      st_next.paddr     = col_half;
      st_next.oy_zero   = (row_half == '0);
      st_next.row_start = (col_half == '0);
      st_next.frame_end = (WW'(col_half) == ow - 1'b1) && (HW'(row_half) == oh - 1'b1);
    end
    st_next.fwd_prev = st_valid && st.emit && (st.paddr == st_next.paddr);
    st_next.fwd_box  = st_valid && st.box_we && (st.baddr == st_next.baddr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      st_valid <= 1'b0;
    end else begin
      st_valid <= accept;
      if (accept) begin
        if ((WW'(col) + WW'(1)) >= w_sat) begin
          col <= '0;
          if ((HW'(row) + HW'(1)) >= h_sat) begin
            row <= '0;
          end else begin
            row <= row + 1'b1;
          end
        end else begin
          col <= col + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st            <= st_next;
      fwd_prev_data <= cur;
      fwd_box_data  <= pair;
    end
  end

  fbp2png_unpack u_unpack (
    .clk  (clk),
    .en   (accept),
    .cfg  (ucfg),
    .word (s_tdata),
    .px   (px)
  );

  fbp2png_ram #(
    .WIDTH (fbp2png_pkg::PAIR_W),
    .DEPTH (BOX_DEPTH)
  ) u_box_store (
    .clk   (clk),
    .we    (st_valid && st.box_we),
    .waddr (st.baddr),
    .wdata (pair),
    .raddr (st_next.baddr),
    .rdata (box_q)
  );

  fbp2png_ram #(
    .WIDTH (fbp2png_pkg::RGB_W),
    .DEPTH (MAX_WIDTH)
  ) u_prev_store (
    .clk   (clk),
    .we    (push),
    .waddr (st.paddr),
    .wdata (cur),
    .raddr (st_next.paddr),
    .rdata (prev_q)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pair[9*k +: 9] = pair_sum[9*k +: 9] + {1'b0, px[8*k +: 8]};
    end
  end

  assign above = st.fwd_box ? fwd_box_data : box_q;
  assign prev  = st.fwd_prev ? fwd_prev_data : prev_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cur_half[8*k +: 8] = 8'(({1'b0, above[9*k +: 9]} + {1'b0, pair[9*k +: 9]}) >> 2);
    end
  end

  assign cur = st.half ? cur_half : px;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      res[8*k +: 8] = st.oy_zero ? cur[8*k +: 8] : cur[8*k +: 8] - prev[8*k +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_sum <= '0;
    end else if (st_valid && st.half && !st.odd_col) begin
      pair_sum <= {1'b0, px[23:16], 1'b0, px[15:8], 1'b0, px[7:0]};
    end
  end

  assign push = st_valid && st.emit;
  assign push_beat = '{frame_end: st.frame_end, row_start: st.row_start,
                       blue: res[7:0], green: res[15:8], red: res[23:16]};

  fbp2png_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_beat (push_beat),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .m_beat    (m_beat),
    .level     (level)
  );

  assign m_tdata = {m_beat.blue, m_beat.green, m_beat.red};
  assign m_tuser = m_beat.row_start;
  assign m_tlast = m_beat.frame_end;

endmodule
`default_nettype wire

/* rtl/fbp2png_ram.sv */
`default_nettype none
module fbp2png_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/fbp2png_unpack.sv */
`default_nettype none
module fbp2png_unpack (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire fbp2png_pkg::unpack_cfg_t            cfg,
  input  wire logic [fbp2png_pkg::PIXEL_W-1:0]     word,
  output logic      [fbp2png_pkg::RGB_W-1:0]       px
);

  function automatic logic [7:0] widen(logic [31:0] w, logic [9:0] layout);
    logic [4:0]  off;
    logic [4:0]  len;
    logic [5:0]  sh;
    logic [31:0] hi;
    logic [6:0]  v;
    logic [7:0]  up;
    logic [7:0]  res;
    off = layout[9:5];
    len = layout[4:0];
    sh  = {1'b0, off} + {1'b0, len} - 6'd8;
    hi  = w >> sh;
    v   = 7'(w >> off) & 7'((8'd1 << len[2:0]) - 8'd1);
    up  = {1'b0, v} << (4'd8 - {1'b0, len[2:0]});
    if (len == 5'd0) begin
      res = 8'd0;
    end else if (len >= 5'd8) begin
      res = hi[7:0];
    end else begin
      res = up | (up >> len[2:0]);
    end
    return res;
  endfunction

  logic [fbp2png_pkg::PIXEL_W-1:0] word_m;

  assign word_m = cfg.wide_pixel ? word : {16'd0, word[15:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      px <= {widen(word_m, cfg.red_layout), widen(word_m, cfg.green_layout),
             widen(word_m, cfg.blue_layout)};
    end
  end

endmodule
`default_nettype wire

/* rtl/fbp2png_outq.sv */
`default_nettype none
module fbp2png_outq (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  push,
  input  wire fbp2png_pkg::out_beat_t                push_beat,
  output logic                                       m_valid,
  input  wire logic                                  m_ready,
  output fbp2png_pkg::out_beat_t                     m_beat,
  output logic      [fbp2png_pkg::OUTQ_PTR_W-1:0]    level
);

  localparam logic [fbp2png_pkg::OUTQ_PTR_W-1:0] LAST =
    fbp2png_pkg::OUTQ_PTR_W'(fbp2png_pkg::OUTQ_DEPTH - 1);

  fbp2png_pkg::out_beat_t slots [fbp2png_pkg::OUTQ_DEPTH];
  logic [fbp2png_pkg::OUTQ_PTR_W-1:0] wr_ptr;
  logic [fbp2png_pkg::OUTQ_PTR_W-1:0] rd_ptr;
  logic pop;

  assign m_valid = (level != '0);
  assign m_beat  = slots[rd_ptr];
  assign pop     = m_valid && m_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

endmodule
`default_nettype wire
